// ===== sv/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants for the first-fit block allocator: transaction
// payloads, action and status codes, table entry layout and default limits.
// ----------------------------------------------------------------------------
package ffba_pkg;

    // Default structural limits.
    localparam int ARENA_LIMIT_DEF  = 65536;
    localparam int HEADER_BYTES_DEF = 16;
    localparam int MIN_GRANULE_DEF  = 4;
    localparam int MAX_GRANULE_DEF  = 4096;
    localparam int MAX_BLOCKS_DEF   = 64;

    // Configuration register indexes and reset values.
    localparam logic CFG_ARENA_BYTES = 1'b0;
    localparam logic CFG_CHUNK_BYTES = 1'b1;
    localparam logic [16:0] ARENA_BYTES_RST = 17'd4096;
    localparam logic [12:0] CHUNK_BYTES_RST = 13'd16;

    typedef enum logic [1:0] {
        ACT_INIT  = 2'd0,
        ACT_ALLOC = 2'd1,
        ACT_FREE  = 2'd2,
        ACT_EXIT  = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BADCFG   = 3'd1,
        ST_TOOBIG   = 3'd2,
        ST_NOSPACE  = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_INUSE    = 3'd5,
        ST_NOTINIT  = 3'd6,
        ST_FULL     = 3'd7
    } t_status;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] request_bytes;
        logic [15:0] block_address;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] data_address;
    } t_rsp;

    // One block of the address-ordered table.
    typedef struct packed {
        logic [15:0] start;
        logic [16:0] size;
        logic        in_use;
    } t_entry;

endpackage

// ===== sv/first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit byte-arena allocator with splitting and coalescing, keeping its
// block table in a single-port synchronous memory.
// ----------------------------------------------------------------------------
// Each transaction is handled on its own; the next one is taken once the
// previous result has been placed in the output register. Init and allocate
// first run a bit-serial remainder unit to round a size up to the granule.
// Scans of the block table read every entry through the registered memory
// port before it is examined, and inserting or removing an entry shifts the
// entries behind it one at a time.
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int ARENA_LIMIT  = ARENA_LIMIT_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int MIN_GRANULE  = MIN_GRANULE_DEF,
    parameter int MAX_GRANULE  = MAX_GRANULE_DEF,
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [16:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_req        i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_rsp        o_out_data
);

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [17:0] HDR   = 18'(HEADER_BYTES);
    localparam logic [17:0] LIMIT = 18'(ARENA_LIMIT);
    localparam logic [CW-1:0] MAXB = CW'(MAX_BLOCKS);

    typedef enum logic [4:0] {
        S_IDLE, S_DIV, S_ROUND, S_A_RD, S_A_CHK, S_A_SHU_RD, S_A_SHU_WR,
        S_A_WR_NEW, S_A_WR_CUR, S_F_RD, S_F_CHK, S_F_NRD, S_F_NCHK,
        S_SHD_RD, S_SHD_WR, S_F_WCUR, S_F_PRD, S_F_PCHK, S_X_RD, S_X_CHK,
        S_DONE
    } t_state;

    // Block table memory.
    t_entry mem [MAX_BLOCKS];
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    t_entry        mem_wd;
    logic          mem_re;
    logic [IW-1:0] mem_ra;
    t_entry        r_rd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= mem[mem_ra];
        end
    end

    // Control and working registers.
    t_state r_state, n_state, r_ret, n_ret;
    logic [16:0] r_arena_bytes;
    logic [12:0] r_chunk_bytes;
    logic [CW-1:0] r_count, n_count, r_idx, n_idx, r_j, n_j;
    logic r_arena_ready, n_arena_ready;
    logic [12:0] r_gran, n_gran;
    t_req r_req, n_req;
    logic [16:0] r_n, n_n;
    t_entry r_cur, n_cur;
    t_status r_status, n_status;
    logic [15:0] r_addr, n_addr;
    logic [16:0] r_divx, n_divx;
    logic [12:0] r_rem, n_rem;
    logic [12:0] r_divd, n_divd;
    logic [4:0] r_bit, n_bit;
    logic r_out_valid, n_out_valid;
    t_rsp r_out, n_out;

    logic [13:0] rem_sh;
    logic [17:0] rounded, need;
    logic [17:0] xsrc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Sequencer: reads, modifies and writes back table entries.
    always_comb begin
        n_state = r_state;  n_ret = r_ret;  n_count = r_count;  n_idx = r_idx;
        n_j = r_j;  n_arena_ready = r_arena_ready;  n_gran = r_gran;
        n_req = r_req;  n_n = r_n;  n_cur = r_cur;  n_status = r_status;
        n_addr = r_addr;  n_divx = r_divx;  n_rem = r_rem;  n_divd = r_divd;
        n_bit = r_bit;  n_out_valid = r_out_valid;  n_out = r_out;
        mem_we = 1'b0;  mem_wa = r_idx[IW-1:0];  mem_wd = r_cur;
        mem_re = 1'b0;  mem_ra = r_idx[IW-1:0];
        rem_sh = {r_rem, r_divx[16]};
        xsrc = (r_req.action == ACT_INIT) ? {1'b0, r_arena_bytes}
                                          : {2'b00, r_req.request_bytes};
        rounded = xsrc + ((r_rem == '0) ? 18'd0 : 18'({1'b0, r_divd} - {1'b0, r_rem}));
        need = {1'b0, r_n} + HDR + {5'd0, r_divd};

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req  = i_in_data;
                    n_addr = '0;
                    n_idx  = '0;
                    n_bit  = 5'd16;
                    n_rem  = '0;
                    n_state = S_DONE;
                    if (i_in_data.action == ACT_INIT) begin
                        if (r_arena_bytes == '0 || {1'b0, r_arena_bytes} > LIMIT ||
                            32'(r_chunk_bytes) < 32'(MIN_GRANULE) ||
                            32'(r_chunk_bytes) > 32'(MAX_GRANULE)) begin
                            n_status = ST_BADCFG;
                        end else begin
                            n_divx  = r_arena_bytes;
                            n_divd  = r_chunk_bytes;
                            n_state = S_DIV;
                        end
                    end else if (!r_arena_ready) begin
                        n_status = ST_NOTINIT;
                    end else if (i_in_data.action == ACT_ALLOC) begin
                        n_divx  = {1'b0, i_in_data.request_bytes};
                        n_divd  = (r_gran == '0) ? 13'd1 : r_gran;
                        n_state = S_DIV;
                    end else if (i_in_data.action == ACT_FREE) begin
                        n_state = S_F_RD;
                    end else begin
                        n_state = S_X_RD;
                    end
                end
            end
            // One restoring remainder step per cycle.
            S_DIV: begin
                if (rem_sh >= {1'b0, r_divd}) begin
                    n_rem = 13'(rem_sh - {1'b0, r_divd});
                end else begin
                    n_rem = rem_sh[12:0];
                end
                n_divx = {r_divx[15:0], 1'b0};
                n_bit  = r_bit - 5'd1;
                if (r_bit == '0) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                if (r_req.action == ACT_INIT) begin
                    n_state = S_DONE;
                    if (rounded + (HDR << 1) > LIMIT) begin
                        n_status = ST_TOOBIG;
                    end else if (rounded < HDR) begin
                        n_status = ST_BADCFG;
                    end else begin
                        mem_we = 1'b1;
                        mem_wa = '0;
                        mem_wd = '{start: 16'(HDR << 1), size: 17'(rounded - HDR),
                                   in_use: 1'b0};
                        n_count = CW'(1);
                        n_arena_ready = 1'b1;
                        n_gran = r_chunk_bytes;
                        n_status = ST_OK;
                    end
                end else begin
                    n_n = rounded[16:0];
                    n_state = S_A_RD;
                end
            end
            // Allocate: first-fit scan.
            S_A_RD: begin
                if (r_idx >= r_count) begin
                    n_status = ST_NOSPACE;
                    n_state = S_DONE;
                end else begin
                    mem_re = 1'b1;
                    n_state = S_A_CHK;
                end
            end
            S_A_CHK: begin
                if (r_rd.in_use || r_rd.size < r_n) begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_A_RD;
                end else begin
                    n_cur = r_rd;
                    n_addr = 16'({2'b00, r_rd.start} + HDR);
                    if ({1'b0, r_rd.size} >= need) begin
                        if (r_count >= MAXB) begin
                            n_status = ST_FULL;
                            n_state = S_DONE;
                        end else begin
                            n_j = r_count;
                            n_state = S_A_SHU_RD;
                        end
                    end else begin
                        mem_we = 1'b1;
                        mem_wd = '{start: r_rd.start, size: r_rd.size, in_use: 1'b1};
                        n_status = ST_OK;
                        n_state = S_DONE;
                    end
                end
            end
            // Open a gap behind the chosen entry.
            S_A_SHU_RD: begin
                if (r_j > r_idx + 1'b1) begin
                    mem_re = 1'b1;
                    mem_ra = IW'(r_j - 1'b1);
                    n_state = S_A_SHU_WR;
                end else begin
                    n_state = S_A_WR_NEW;
                end
            end
            S_A_SHU_WR: begin
                mem_we = 1'b1;
                mem_wa = r_j[IW-1:0];
                mem_wd = r_rd;
                n_j = r_j - 1'b1;
                n_state = S_A_SHU_RD;
            end
            S_A_WR_NEW: begin
                mem_we = 1'b1;
                mem_wa = IW'(r_idx + 1'b1);
                mem_wd = '{start: 16'({2'b00, r_cur.start} + HDR + {1'b0, r_n}),
                           size: 17'({1'b0, r_cur.size} - {1'b0, r_n} - HDR),
                           in_use: 1'b0};
                n_count = r_count + 1'b1;
                n_state = S_A_WR_CUR;
            end
            S_A_WR_CUR: begin
                mem_we = 1'b1;
                mem_wd = '{start: r_cur.start, size: r_n, in_use: 1'b1};
                n_status = ST_OK;
                n_state = S_DONE;
            end
            // Free: look up the block by its data address.
            S_F_RD: begin
                if (r_idx >= r_count) begin
                    n_status = ST_NOTFOUND;
                    n_state = S_DONE;
                end else begin
                    mem_re = 1'b1;
                    n_state = S_F_CHK;
                end
            end
            S_F_CHK: begin
                if (r_rd.in_use &&
                    ({2'b00, r_rd.start} + HDR) == {2'b00, r_req.block_address}) begin
                    n_cur = '{start: r_rd.start, size: r_rd.size, in_use: 1'b0};
                    n_state = S_F_NRD;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_F_RD;
                end
            end
            S_F_NRD: begin
                if (r_idx + 1'b1 < r_count) begin
                    mem_re = 1'b1;
                    mem_ra = IW'(r_idx + 1'b1);
                    n_state = S_F_NCHK;
                end else begin
                    n_state = S_F_WCUR;
                end
            end
            S_F_NCHK: begin
                if (!r_rd.in_use) begin
                    n_cur.size = 17'({1'b0, r_cur.size} + HDR + {1'b0, r_rd.size});
                    n_j = r_idx + 1'b1;
                    n_ret = S_F_WCUR;
                    n_state = S_SHD_RD;
                end else begin
                    n_state = S_F_WCUR;
                end
            end
            // Close the gap left by a merged entry.
            S_SHD_RD: begin
                if (r_j + 1'b1 < r_count) begin
                    mem_re = 1'b1;
                    mem_ra = IW'(r_j + 1'b1);
                    n_state = S_SHD_WR;
                end else begin
                    n_count = r_count - 1'b1;
                    n_state = r_ret;
                end
            end
            S_SHD_WR: begin
                mem_we = 1'b1;
                mem_wa = r_j[IW-1:0];
                mem_wd = r_rd;
                n_j = r_j + 1'b1;
                n_state = S_SHD_RD;
            end
            S_F_WCUR: begin
                mem_we = 1'b1;
                n_status = ST_OK;
                n_state = (r_idx != '0) ? S_F_PRD : S_DONE;
            end
            S_F_PRD: begin
                mem_re = 1'b1;
                mem_ra = IW'(r_idx - 1'b1);
                n_state = S_F_PCHK;
            end
            S_F_PCHK: begin
                if (!r_rd.in_use) begin
                    mem_we = 1'b1;
                    mem_wa = IW'(r_idx - 1'b1);
                    mem_wd = '{start: r_rd.start,
                               size: 17'({1'b0, r_rd.size} + HDR + {1'b0, r_cur.size}),
                               in_use: 1'b0};
                    n_j = r_idx;
                    n_ret = S_DONE;
                    n_state = S_SHD_RD;
                end else begin
                    n_state = S_DONE;
                end
            end
            // Exit: release only when nothing is in use.
            S_X_RD: begin
                if (r_idx >= r_count) begin
                    n_arena_ready = 1'b0;
                    n_count = '0;
                    n_status = ST_OK;
                    n_state = S_DONE;
                end else begin
                    mem_re = 1'b1;
                    n_state = S_X_CHK;
                end
            end
            S_X_CHK: begin
                if (r_rd.in_use) begin
                    n_status = ST_INUSE;
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx + 1'b1;
                    n_state = S_X_RD;
                end
            end
            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out.status = r_status;
                    n_out.data_address = (r_status == ST_OK) ? r_addr : 16'd0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, configuration and working registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret <= S_DONE;
            r_count <= '0;
            r_arena_ready <= 1'b0;
            r_gran <= '0;
            r_out_valid <= 1'b0;
            r_arena_bytes <= ARENA_BYTES_RST;
            r_chunk_bytes <= CHUNK_BYTES_RST;
        end else begin
            r_state <= n_state;
            r_ret <= n_ret;
            r_count <= n_count;
            r_arena_ready <= n_arena_ready;
            r_gran <= n_gran;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_ARENA_BYTES) begin
                    r_arena_bytes <= i_cfg_data;
                end else begin
                    r_chunk_bytes <= i_cfg_data[12:0];
                end
            end
        end
        r_idx <= n_idx;
        r_j <= n_j;
        r_req <= n_req;
        r_n <= n_n;
        r_cur <= n_cur;
        r_status <= n_status;
        r_addr <= n_addr;
        r_divx <= n_divx;
        r_rem <= n_rem;
        r_divd <= n_divd;
        r_bit <= n_bit;
        r_out <= n_out;
    end

    // The table never grows beyond its capacity.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAXB)
        else $error("block table count exceeds capacity");

    // Without an arena the table is empty.
    a_empty_unready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_arena_ready |-> r_count == '0)
        else $error("entries present without an arena");

    // A failed transaction never reports an address.
    a_fail_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OK) |-> r_out.data_address == '0)
        else $error("address reported for a failed transaction");

    // A new result is only loaded when the previous one has been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid && $stable(r_out))
        else $error("pending result overwritten");

endmodule
